// File: rtl/stq_pkg.sv
package stq_pkg;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_START_REL = 3'd1;
    localparam logic [2:0] CMD_START_ABS = 3'd2;
    localparam logic [2:0] CMD_STOP      = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam int MAX_RESULTS = 16;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 24;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   fired_id;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_rsp;

endpackage

// File: rtl/stq_in_if.sv
interface stq_in_if import stq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       cmd;
    logic [ID_W-1:0]  timer_id;
    logic [CNT_W-1:0] ticks;

    modport source (output valid, output cmd, output timer_id, output ticks, input ready);
    modport sink (input valid, input cmd, input timer_id, input ticks, output ready);
endinterface

// File: rtl/stq_out_if.sv
interface stq_out_if import stq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [ID_W-1:0]  fired_id;
    logic [CNT_W-1:0] count;
    logic             last;

    modport source (output valid, output kind, output fired_id, output count, output last,
                    input ready);
    modport sink (input valid, input kind, input fired_id, input count, input last,
                  output ready);
endinterface

// File: rtl/sorted_timer_queue_top.sv
// sorted timer queue: 32-bit counter plus a queue of timers kept in expiry order
// i_req request: cmd 0 tick, 1 start relative, 2 start absolute, 3 stop, 4 read
// o_rsp results: fired timers of a tick in queue order, or a counter read reply;
// last marks the final result of a request
// i_cfg_we / i_cfg_wdata set the counter increment per tick (0 acts as 1)
// one request is worked on at a time; the queue order and expiry times live in
// two memories with registered reads, walked one entry at a time
// read: the reply enters the result register from the S_RD_EMIT state
// tick: reads the head entry's order and expiry and compares them with the counter;
// each due timer is removed by moving the later entries down
// start: drops an old copy of the timer, scans the queue for the slot and
// moves the later entries to open it
// stop: scans the queue for the entry and moves the later entries to close the gap
// the result register lets a new request enter while a result waits
// a stalled receiver holds the queue in its current step until taken
// reset clears the counter, the queue and the increment back to one
module sorted_timer_queue_top import stq_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    stq_in_if.sink           i_req,
    stq_out_if.source        o_rsp
);

    t_rsp rsp;
    logic rsp_valid;
    logic rsp_ready;

    stq_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (rsp),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready)
    );

    stq_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rsp       (rsp),
        .i_rsp_valid (rsp_valid),
        .o_rsp_ready (rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// File: rtl/stq_ctrl.sv
module stq_ctrl import stq_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    stq_in_if.sink           i_req,
    output t_rsp             o_rsp,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [17:0] {
        S_IDLE     = 18'(1) << 0,
        S_TK_HEAD  = 18'(1) << 1,
        S_TK_EXP   = 18'(1) << 2,
        S_TK_CMP   = 18'(1) << 3,
        S_TK_EMIT  = 18'(1) << 4,
        S_FLUSH    = 18'(1) << 5,
        S_RD_EMIT  = 18'(1) << 6,
        S_DQ_CHK   = 18'(1) << 7,
        S_DQ_RD    = 18'(1) << 8,
        S_DQ_CMP   = 18'(1) << 9,
        S_EN_START = 18'(1) << 10,
        S_EN_RD    = 18'(1) << 11,
        S_EN_EXP   = 18'(1) << 12,
        S_EN_CMP   = 18'(1) << 13,
        S_SU_RD    = 18'(1) << 14,
        S_SU_WR    = 18'(1) << 15,
        S_SD_RD    = 18'(1) << 16,
        S_SD_WR    = 18'(1) << 17
    } t_state;

    logic [IW-1:0]    order_mem [NUM_TIMERS];
    logic [CNT_W-1:0] expiry_mem [NUM_TIMERS];

    t_state                r_state, n_state;
    t_state                r_ret, n_ret;
    logic [CFG_W-1:0]      r_cfg;
    logic [CNT_W-1:0]      r_counter, n_counter;
    logic [LW-1:0]         r_len, n_len;
    logic [NUM_TIMERS-1:0] r_flag, n_flag;
    logic [LW-1:0]         r_pos, n_pos;
    logic [LW-1:0]         r_sh, n_sh;
    logic [IW-1:0]         r_id, n_id;
    logic [IW-1:0]         r_cur, n_cur;
    logic [IW-1:0]         r_pend, n_pend;
    logic                  r_pend_v, n_pend_v;
    logic                  r_is_start, n_is_start;
    logic [CNT_W-1:0]      r_when, n_when;
    logic [NW-1:0]         r_n, n_n;
    logic [IW-1:0]         r_ord_q;
    logic [CNT_W-1:0]      r_exp_q;

    logic             ord_we;
    logic [IW-1:0]    ord_ra, ord_wa, ord_wd;
    logic             exp_we;
    logic [IW-1:0]    exp_ra, exp_wa;
    logic [CNT_W-1:0] exp_wd;
    logic [CNT_W-1:0] tick_diff, ins_diff;
    logic [CFG_W-1:0] inc;
    logic             id_ok;
    t_state           dq_done;

    assign inc       = (r_cfg == '0) ? CFG_W'(1) : r_cfg;
    assign tick_diff = r_counter - r_exp_q;
    assign ins_diff  = r_when - r_exp_q;
    assign id_ok     = 32'(i_req.timer_id) < NUM_TIMERS;
    assign dq_done   = r_is_start ? S_EN_START : S_IDLE;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_counter  = r_counter;
        n_len      = r_len;
        n_flag     = r_flag;
        n_pos      = r_pos;
        n_sh       = r_sh;
        n_id       = r_id;
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_is_start = r_is_start;
        n_when     = r_when;
        n_n        = r_n;
        ord_we     = 1'b0;
        ord_ra     = '0;
        ord_wa     = '0;
        ord_wd     = '0;
        exp_we     = 1'b0;
        exp_ra     = '0;
        exp_wa     = '0;
        exp_wd     = '0;
        o_rsp_valid    = 1'b0;
        o_rsp.kind     = KIND_FIRED;
        o_rsp.fired_id = ID_W'(r_pend);
        o_rsp.count    = r_counter;
        o_rsp.last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_id = IW'(i_req.timer_id);
                    unique case (i_req.cmd)
                        CMD_TICK: begin
                            n_counter = r_counter + CNT_W'(inc);
                            n_n       = '0;
                            n_pend_v  = 1'b0;
                            n_state   = S_TK_HEAD;
                        end
                        CMD_START_REL, CMD_START_ABS: begin
                            n_when = (i_req.cmd == CMD_START_REL) ?
                                     r_counter + i_req.ticks : i_req.ticks;
                            n_is_start = 1'b1;
                            if (id_ok) begin
                                n_state = S_DQ_CHK;
                            end
                        end
                        CMD_STOP: begin
                            n_is_start = 1'b0;
                            if (id_ok) begin
                                n_state = S_DQ_CHK;
                            end
                        end
                        CMD_READ: begin
                            n_state = S_RD_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TK_HEAD: begin
                if (r_len == '0 || r_n == NW'(MAX_RESULTS)) begin
                    n_state = S_FLUSH;
                end else begin
                    ord_ra  = '0;
                    n_state = S_TK_EXP;
                end
            end
            S_TK_EXP: begin
                exp_ra  = r_ord_q;
                n_cur   = r_ord_q;
                n_state = S_TK_CMP;
            end
            S_TK_CMP: begin
                if (tick_diff[CNT_W-1]) begin
                    n_state = S_FLUSH;
                end else begin
                    n_flag[r_cur] = 1'b0;
                    n_n           = r_n + NW'(1);
                    if (r_pend_v) begin
                        n_state = S_TK_EMIT;
                    end else begin
                        n_pend   = r_cur;
                        n_pend_v = 1'b1;
                        n_pos    = '0;
                        n_ret    = S_TK_HEAD;
                        n_state  = S_SD_RD;
                    end
                end
            end
            S_TK_EMIT: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_pend  = r_cur;
                    n_pos   = '0;
                    n_ret   = S_TK_HEAD;
                    n_state = S_SD_RD;
                end
            end
            S_FLUSH: begin
                if (r_pend_v) begin
                    o_rsp_valid = 1'b1;
                    o_rsp.last  = 1'b1;
                    if (i_rsp_ready) begin
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD_EMIT: begin
                o_rsp_valid    = 1'b1;
                o_rsp.kind     = KIND_READ;
                o_rsp.fired_id = '0;
                o_rsp.last     = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_DQ_CHK: begin
                if (!r_flag[r_id]) begin
                    n_state = dq_done;
                end else begin
                    n_pos   = '0;
                    n_state = S_DQ_RD;
                end
            end
            S_DQ_RD: begin
                if (r_pos < r_len) begin
                    ord_ra  = r_pos[IW-1:0];
                    n_state = S_DQ_CMP;
                end else begin
                    n_flag[r_id] = 1'b0;
                    n_state      = dq_done;
                end
            end
            S_DQ_CMP: begin
                if (r_ord_q == r_id) begin
                    n_flag[r_id] = 1'b0;
                    n_ret        = dq_done;
                    n_state      = S_SD_RD;
                end else begin
                    n_pos   = r_pos + LW'(1);
                    n_state = S_DQ_RD;
                end
            end
            S_EN_START: begin
                if (r_len >= LW'(NUM_TIMERS)) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos   = '0;
                    n_state = S_EN_RD;
                end
            end
            S_EN_RD: begin
                if (r_pos < r_len) begin
                    ord_ra  = r_pos[IW-1:0];
                    n_state = S_EN_EXP;
                end else begin
                    n_sh    = r_len;
                    n_state = S_SU_RD;
                end
            end
            S_EN_EXP: begin
                exp_ra  = r_ord_q;
                n_state = S_EN_CMP;
            end
            S_EN_CMP: begin
                if (ins_diff[CNT_W-1]) begin
                    n_sh    = r_len;
                    n_state = S_SU_RD;
                end else begin
                    n_pos   = r_pos + LW'(1);
                    n_state = S_EN_RD;
                end
            end
            S_SU_RD: begin
                if (r_sh > r_pos) begin
                    ord_ra  = IW'(r_sh - LW'(1));
                    n_state = S_SU_WR;
                end else begin
                    ord_we        = 1'b1;
                    ord_wa        = r_pos[IW-1:0];
                    ord_wd        = r_id;
                    exp_we        = 1'b1;
                    exp_wa        = r_id;
                    exp_wd        = r_when;
                    n_flag[r_id]  = 1'b1;
                    n_len         = r_len + LW'(1);
                    n_state       = S_IDLE;
                end
            end
            S_SU_WR: begin
                ord_we  = 1'b1;
                ord_wa  = r_sh[IW-1:0];
                ord_wd  = r_ord_q;
                n_sh    = r_sh - LW'(1);
                n_state = S_SU_RD;
            end
            S_SD_RD: begin
                if (LW'(r_pos + LW'(1)) < r_len) begin
                    ord_ra  = IW'(r_pos + LW'(1));
                    n_state = S_SD_WR;
                end else begin
                    n_len   = r_len - LW'(1);
                    n_state = r_ret;
                end
            end
            S_SD_WR: begin
                ord_we  = 1'b1;
                ord_wa  = r_pos[IW-1:0];
                ord_wd  = r_ord_q;
                n_pos   = r_pos + LW'(1);
                n_state = S_SD_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ord_q <= order_mem[ord_ra];
        r_exp_q <= expiry_mem[exp_ra];
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        if (exp_we) begin
            expiry_mem[exp_wa] <= exp_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_cfg     <= CFG_W'(1);
            r_counter <= '0;
            r_len     <= '0;
            r_flag    <= '0;
            r_pend_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_counter <= n_counter;
            r_len     <= n_len;
            r_flag    <= n_flag;
            r_pend_v  <= n_pend_v;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_sh       <= n_sh;
        r_id       <= n_id;
        r_cur      <= n_cur;
        r_pend     <= n_pend;
        r_is_start <= n_is_start;
        r_when     <= n_when;
        r_n        <= n_n;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(NUM_TIMERS))
        else $error("queue length above capacity");

    a_flag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_flag) == int'(r_len)))
        else $error("queued flags disagree with queue length");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready && o_rsp.last) |=> (r_state == S_IDLE))
        else $error("final result not followed by idle");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SD_WR) |-> (LW'(r_pos + LW'(1)) < r_len))
        else $error("order shift past queue end");

endmodule

// File: rtl/stq_out_buf.sv
module stq_out_buf import stq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rsp      i_rsp,
    input  logic      i_rsp_valid,
    output logic      o_rsp_ready,
    stq_out_if.source o_rsp
);

    logic r_v;
    t_rsp r_rsp;

    assign o_rsp_ready    = !r_v || o_rsp.ready;
    assign o_rsp.valid    = r_v;
    assign o_rsp.kind     = r_rsp.kind;
    assign o_rsp.fired_id = r_rsp.fired_id;
    assign o_rsp.count    = r_rsp.count;
    assign o_rsp.last     = r_rsp.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_rsp_ready) begin
            r_v <= i_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rsp_ready && i_rsp_valid) begin
            r_rsp <= i_rsp;
        end
    end

endmodule
